// File: src/thick_line_pixel_generator_unit_defines.svh
// Assertion helpers for the thick line pixel generator.
// Each macro expects clk and rst_n in scope.
`ifndef THICK_LINE_PIXEL_GENERATOR_UNIT_DEFINES_SVH
`define THICK_LINE_PIXEL_GENERATOR_UNIT_DEFINES_SVH

`define TLPG_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define TLPG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define TLPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tlpg_pkg.sv
`timescale 1ns / 1ps

package tlpg_pkg;

  localparam int FIELD_COORD_W = 10;
  localparam int COLOR_W       = 8;
  localparam int THICK_W       = 6;
  localparam int PIXEL_W       = 12;

  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic signed [PIXEL_W-1:0] pixel_coord_t;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

endpackage

// File: src/tlpg_in_if.sv
`timescale 1ns / 1ps

interface tlpg_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic [tlpg_pkg::FIELD_COORD_W-1:0]   begin_x;
  logic [tlpg_pkg::FIELD_COORD_W-1:0]   begin_y;
  logic [tlpg_pkg::FIELD_COORD_W-1:0]   finish_x;
  logic [tlpg_pkg::FIELD_COORD_W-1:0]   finish_y;
  tlpg_pkg::color_t                     draw_color;
  logic [tlpg_pkg::THICK_W-1:0]         thickness;

  modport source (
    output valid, func, begin_x, begin_y, finish_x, finish_y, draw_color, thickness,
    input  ready
  );
  modport sink (
    input  valid, func, begin_x, begin_y, finish_x, finish_y, draw_color, thickness,
    output ready
  );
endinterface

// File: src/tlpg_out_if.sv
`timescale 1ns / 1ps

interface tlpg_out_if;
  logic                   valid;
  logic                   ready;
  logic                   pixel_valid;
  tlpg_pkg::pixel_coord_t pixel_x;
  tlpg_pkg::pixel_coord_t pixel_y;
  tlpg_pkg::color_t       pixel_color;
  logic                   last_pixel;

  modport source (
    output valid, pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel,
    output ready
  );
endinterface

// File: src/thick_line_pixel_generator_unit.sv
// channel   dir  handshake        payload
// in_req    in   valid / ready    func, endpoints, draw_color, thickness
// out_rsp   out  valid / ready    pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel
//
// One request per cycle unless the response register stalls; each request yields one registered response.
// Line state updates and the response are computed in one pass from the line registers.
// The response register stalls on out_rsp.ready; in_req.ready follows it combinationally.
// Synchronous active-low reset clears the line state (idle) and the response valid.
`timescale 1ns / 1ps
`include "thick_line_pixel_generator_unit_defines.svh"

module thick_line_pixel_generator_unit #(
  parameter int COORD_BITS    = 10,
  parameter int MAX_THICKNESS = 63
) (
  input  logic          clk,
  input  logic          rst_n,
  tlpg_in_if.sink       in_req,
  tlpg_out_if.source    out_rsp
);

  localparam int CB  = COORD_BITS;
  localparam int RW  = COORD_BITS + 2;
  localparam int PW  = tlpg_pkg::PIXEL_W;
  localparam int TBW = $clog2(MAX_THICKNESS + 1);
  localparam int TCW = (TBW > tlpg_pkg::THICK_W) ? TBW : tlpg_pkg::THICK_W;

  // line state
  logic [CB-1:0]          walk_r,    walk_nxt;
  logic [CB-1:0]          limit_r,   limit_nxt;
  logic [CB-1:0]          start_r,   start_nxt;
  logic [CB-1:0]          den_r,     den_nxt;
  logic signed [CB:0]     num_r,     num_nxt;
  logic signed [RW-1:0]   rem_r,     rem_nxt;
  logic [PW-1:0]          cross_r,   cross_nxt;
  logic [PW-1:0]          base_r,    base_nxt;
  logic [PW-1:0]          offset_r,  offset_nxt;
  logic [TBW-1:0]         passes_r,  passes_nxt;
  tlpg_pkg::color_t       color_r,   color_nxt;
  logic                   steep_r,   steep_nxt;
  logic                   rev_r,     rev_nxt;
  logic                   busy_r,    busy_nxt;

  // response register
  logic                   out_valid_r, out_valid_nxt;
  logic                   pix_valid_r, pix_valid_nxt;
  logic [PW-1:0]          pix_x_r,     pix_x_nxt;
  logic [PW-1:0]          pix_y_r,     pix_y_nxt;
  tlpg_pkg::color_t       pix_color_r, pix_color_nxt;
  logic                   last_r,      last_nxt;

  logic                   in_fire;
  logic                   is_start;

  // start decode
  logic [CB-1:0]          fx, fy, sx, sy;
  logic signed [CB:0]     dx, dy;
  logic [CB-1:0]          adx, ady;
  logic [TCW-1:0]         th_ext, th_sat;
  logic                   st_steep, st_rev;
  logic [CB-1:0]          st_limit, st_start;
  logic [CB-1:0]          st_den;
  logic signed [CB:0]     st_num;
  logic [PW-1:0]          st_base;

  // advance
  logic [CB:0]            walk_inc;
  logic                   pass_end;
  logic [TBW-1:0]         passes_dec;
  logic [PW-1:0]          offset_dec;
  logic signed [RW-1:0]   rem_sum;
  logic signed [RW-1:0]   den_ext;

  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign in_fire      = in_req.valid && in_req.ready;
  assign is_start     = (in_req.func == tlpg_pkg::FUNC_START);

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.pixel_valid = pix_valid_r;
  assign out_rsp.pixel_x     = $signed(pix_x_r);
  assign out_rsp.pixel_y     = $signed(pix_y_r);
  assign out_rsp.pixel_color = pix_color_r;
  assign out_rsp.last_pixel  = last_r;

  always_comb begin
    fx = CB'(in_req.begin_x);
    fy = CB'(in_req.begin_y);
    sx = CB'(in_req.finish_x);
    sy = CB'(in_req.finish_y);
    dx = $signed({1'b0, sx}) - $signed({1'b0, fx});
    dy = $signed({1'b0, sy}) - $signed({1'b0, fy});
    adx = dx[CB] ? CB'(-dx) : CB'(dx);
    ady = dy[CB] ? CB'(-dy) : CB'(dy);
    th_ext = TCW'(in_req.thickness);
    th_sat = (th_ext > TCW'(MAX_THICKNESS)) ? TCW'(MAX_THICKNESS) : th_ext;
    st_steep = ady > adx;
    if (!st_steep) begin
      st_rev   = fx > sx;
      st_limit = st_rev ? fx : sx;
      st_start = st_rev ? sx : fx;
      st_base  = PW'(st_rev ? sy : fy);
      st_den   = adx;
      st_num   = dx[CB] ? -dy : dy;
    end else begin
      st_rev   = fy > sy;
      st_limit = st_rev ? fy : sy;
      st_start = st_rev ? sy : fy;
      st_base  = PW'(st_rev ? sx : fx);
      st_den   = ady;
      st_num   = dy[CB] ? -dx : dx;
    end
  end

  always_comb begin
    walk_inc   = {1'b0, walk_r} + {{CB{1'b0}}, 1'b1};
    pass_end   = walk_inc >= {1'b0, limit_r};
    passes_dec = passes_r - TBW'(1);
    offset_dec = offset_r - PW'(1);
    rem_sum    = rem_r + RW'(num_r);
    den_ext    = $signed(RW'(den_r));
  end

  always_comb begin
    walk_nxt   = walk_r;
    limit_nxt  = limit_r;
    start_nxt  = start_r;
    den_nxt    = den_r;
    num_nxt    = num_r;
    rem_nxt    = rem_r;
    cross_nxt  = cross_r;
    base_nxt   = base_r;
    offset_nxt = offset_r;
    passes_nxt = passes_r;
    color_nxt  = color_r;
    steep_nxt  = steep_r;
    rev_nxt    = rev_r;
    busy_nxt   = busy_r;

    out_valid_nxt = out_valid_r;
    pix_valid_nxt = pix_valid_r;
    pix_x_nxt     = pix_x_r;
    pix_y_nxt     = pix_y_r;
    pix_color_nxt = pix_color_r;
    last_nxt      = last_r;

    if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      out_valid_nxt = 1'b1;
      pix_valid_nxt = 1'b0;
      pix_x_nxt     = '0;
      pix_y_nxt     = '0;
      pix_color_nxt = '0;
      last_nxt      = 1'b0;
      if (is_start) begin
        limit_nxt  = st_limit;
        start_nxt  = st_start;
        den_nxt    = st_den;
        num_nxt    = st_num;
        base_nxt   = st_base;
        steep_nxt  = st_steep;
        rev_nxt    = st_rev;
        color_nxt  = in_req.draw_color;
        passes_nxt = TBW'(th_sat);
        offset_nxt = PW'(th_sat >> 1);
        busy_nxt   = (th_sat != '0) && ((adx != '0) || (ady != '0));
        walk_nxt   = st_start;
        cross_nxt  = st_base + PW'(th_sat >> 1);
        rem_nxt    = '0;
      end else if (busy_r) begin
        pix_valid_nxt = 1'b1;
        pix_color_nxt = color_r;
        if (!steep_r) begin
          pix_x_nxt = PW'(walk_r);
          pix_y_nxt = cross_r - PW'(rev_r);
        end else begin
          pix_x_nxt = cross_r;
          pix_y_nxt = PW'(walk_r);
        end
        walk_nxt = CB'(walk_inc);
        if (pass_end) begin
          passes_nxt = passes_dec;
          offset_nxt = offset_dec;
          if (passes_dec == '0) begin
            busy_nxt = 1'b0;
            last_nxt = 1'b1;
          end else begin
            walk_nxt  = start_r;
            cross_nxt = base_r + offset_dec;
            rem_nxt   = '0;
          end
        end else if (rem_sum >= den_ext) begin
          rem_nxt   = rem_sum - den_ext;
          cross_nxt = cross_r + PW'(1);
        end else if (rem_sum < 0) begin
          rem_nxt   = rem_sum + den_ext;
          cross_nxt = cross_r - PW'(1);
        end else begin
          rem_nxt = rem_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r      <= '0;
      limit_r     <= '0;
      start_r     <= '0;
      den_r       <= '0;
      num_r       <= '0;
      rem_r       <= '0;
      cross_r     <= '0;
      base_r      <= '0;
      offset_r    <= '0;
      passes_r    <= '0;
      color_r     <= '0;
      steep_r     <= 1'b0;
      rev_r       <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      walk_r      <= walk_nxt;
      limit_r     <= limit_nxt;
      start_r     <= start_nxt;
      den_r       <= den_nxt;
      num_r       <= num_nxt;
      rem_r       <= rem_nxt;
      cross_r     <= cross_nxt;
      base_r      <= base_nxt;
      offset_r    <= offset_nxt;
      passes_r    <= passes_nxt;
      color_r     <= color_nxt;
      steep_r     <= steep_nxt;
      rev_r       <= rev_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_valid_r <= pix_valid_nxt;
    pix_x_r     <= pix_x_nxt;
    pix_y_r     <= pix_y_nxt;
    pix_color_r <= pix_color_nxt;
    last_r      <= last_nxt;
  end

  `TLPG_ASSERT_IMPL(a_rem_range, busy_r, (rem_r >= 0) && (rem_r < den_ext), "remainder out of range")
  `TLPG_ASSERT_IMPL(a_walk_range, busy_r, walk_r < limit_r, "walk position past limit")
  `TLPG_ASSERT_NEXT(a_idle_adv, in_fire && !is_start && !busy_r, out_valid_r && !pix_valid_r, "idle advance produced a pixel")
  `TLPG_ASSERT_NEXT(a_last_idle, in_fire && !is_start && busy_r && last_nxt, !busy_r && last_r, "line still busy after last pixel")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic                               func;
    logic [tlpg_pkg::FIELD_COORD_W-1:0] x0;
    logic [tlpg_pkg::FIELD_COORD_W-1:0] y0;
    logic [tlpg_pkg::FIELD_COORD_W-1:0] x1;
    logic [tlpg_pkg::FIELD_COORD_W-1:0] y1;
    tlpg_pkg::color_t                   color;
    logic [tlpg_pkg::THICK_W-1:0]       thick;
  } line_req_t;

  typedef struct packed {
    logic                   pvalid;
    tlpg_pkg::pixel_coord_t x;
    tlpg_pkg::pixel_coord_t y;
    tlpg_pkg::color_t       color;
    logic                   last;
  } pixel_rsp_t;

  logic clk;
  logic rst_n = 1'b0;

  tlpg_in_if  in_req ();
  tlpg_out_if out_rsp ();

  thick_line_pixel_generator_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  line_req_t  pending_q[$];
  pixel_rsp_t pixel_exp_q[$];
  line_req_t  next_req;
  pixel_rsp_t got_rsp;
  pixel_rsp_t want_rsp;

  int n_errors    = 0;
  int n_accepted  = 0;
  int n_starts    = 0;
  int n_pixels    = 0;
  int n_completed = 0;
  int n_idle_rsp  = 0;

  // rasterizer state mirror
  logic [tlpg_pkg::FIELD_COORD_W-1:0] ln_x0 = '0, ln_y0 = '0, ln_x1 = '0, ln_y1 = '0;
  tlpg_pkg::color_t ln_color  = '0;
  int     ln_passes = 0;
  int     ln_offset = 0;
  int     ln_pos    = 0;
  int     ln_end    = 0;
  int     ln_cross  = 0;
  int     ln_rem    = 0;
  bit     ln_steep  = 1'b0;
  bit     ln_rev    = 1'b0;
  bit     ln_active = 1'b0;

  function automatic void line_axis(output int den, output int num, output int start,
                                    output int base);
    int dx, dy;
    dx = int'(ln_x1) - int'(ln_x0);
    dy = int'(ln_y1) - int'(ln_y0);
    if (!ln_steep) begin
      den   = dx < 0 ? -dx : dx;
      num   = dx < 0 ? -dy : dy;
      start = ln_rev ? int'(ln_x1) : int'(ln_x0);
      base  = ln_rev ? int'(ln_y1) : int'(ln_y0);
    end else begin
      den   = dy < 0 ? -dy : dy;
      num   = dy < 0 ? -dx : dx;
      start = ln_rev ? int'(ln_y1) : int'(ln_y0);
      base  = ln_rev ? int'(ln_x1) : int'(ln_x0);
    end
  endfunction

  function automatic void start_pass();
    int den, num, start, base;
    line_axis(den, num, start, base);
    ln_pos   = start;
    ln_cross = base + ln_offset;
    ln_rem   = 0;
  endfunction

  function automatic pixel_rsp_t raster_step(line_req_t r);
    pixel_rsp_t o;
    int dx, dy, adx, ady, px, py, den, num, start, base;
    o = '0;
    if (r.func == tlpg_pkg::FUNC_START) begin
      ln_x0    = r.x0;
      ln_y0    = r.y0;
      ln_x1    = r.x1;
      ln_y1    = r.y1;
      ln_color = r.color;
      dx  = int'(ln_x1) - int'(ln_x0);
      dy  = int'(ln_y1) - int'(ln_y0);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      ln_steep = ady > adx;
      if (!ln_steep) begin
        ln_rev = ln_x0 > ln_x1;
        ln_end = ln_rev ? int'(ln_x0) : int'(ln_x1);
      end else begin
        ln_rev = ln_y0 > ln_y1;
        ln_end = ln_rev ? int'(ln_y0) : int'(ln_y1);
      end
      ln_passes = int'(r.thick);
      ln_offset = int'(r.thick) / 2;
      ln_active = (r.thick != 0) && (adx != 0 || ady != 0);
      if (ln_active) begin
        start_pass();
      end else begin
        ln_pos   = ln_end;
        ln_cross = 0;
        ln_rem   = 0;
      end
      return o;
    end
    if (!ln_active) return o;
    if (!ln_steep) begin
      px = ln_pos;
      py = ln_cross - (ln_rev ? 1 : 0);
    end else begin
      px = ln_cross;
      py = ln_pos;
    end
    o.pvalid = 1'b1;
    o.x      = px[tlpg_pkg::PIXEL_W-1:0];
    o.y      = py[tlpg_pkg::PIXEL_W-1:0];
    o.color  = ln_color;
    line_axis(den, num, start, base);
    ln_pos = ln_pos + 1;
    if (ln_pos >= ln_end) begin
      ln_passes = ln_passes - 1;
      ln_offset = ln_offset - 1;
      if (ln_passes == 0) begin
        ln_active = 1'b0;
        o.last    = 1'b1;
      end else begin
        start_pass();
      end
    end else begin
      ln_rem = ln_rem + num;
      if (ln_rem >= den) begin
        ln_rem   = ln_rem - den;
        ln_cross = ln_cross + 1;
      end else if (ln_rem < 0) begin
        ln_rem   = ln_rem + den;
        ln_cross = ln_cross - 1;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, pixel_rsp_t got, pixel_rsp_t want);
    n_errors++;
    if (n_errors <= 40)
      $display("[%0t] %s: got v=%0b x=%0d y=%0d c=%0d l=%0b, want v=%0b x=%0d y=%0d c=%0d l=%0b",
               $time, what, got.pvalid, got.x, got.y, got.color, got.last,
               want.pvalid, want.x, want.y, want.color, want.last);
  endtask

  task automatic add_start(int x0, int y0, int x1, int y1, int color, int thick);
    line_req_t r;
    r.func  = tlpg_pkg::FUNC_START;
    r.x0    = x0[tlpg_pkg::FIELD_COORD_W-1:0];
    r.y0    = y0[tlpg_pkg::FIELD_COORD_W-1:0];
    r.x1    = x1[tlpg_pkg::FIELD_COORD_W-1:0];
    r.y1    = y1[tlpg_pkg::FIELD_COORD_W-1:0];
    r.color = color[tlpg_pkg::COLOR_W-1:0];
    r.thick = thick[tlpg_pkg::THICK_W-1:0];
    pending_q.push_back(r);
    n_starts++;
  endtask

  // advance requests carry junk in the unused fields
  task automatic add_advances(int n);
    line_req_t   r;
    logic [31:0] rnd;
    repeat (n) begin
      r.func  = tlpg_pkg::FUNC_ADVANCE;
      rnd     = $urandom;
      r.x0    = rnd[tlpg_pkg::FIELD_COORD_W-1:0];
      rnd     = $urandom;
      r.y0    = rnd[tlpg_pkg::FIELD_COORD_W-1:0];
      rnd     = $urandom;
      r.x1    = rnd[tlpg_pkg::FIELD_COORD_W-1:0];
      rnd     = $urandom;
      r.y1    = rnd[tlpg_pkg::FIELD_COORD_W-1:0];
      rnd     = $urandom;
      r.color = rnd[tlpg_pkg::COLOR_W-1:0];
      rnd     = $urandom;
      r.thick = rnd[tlpg_pkg::THICK_W-1:0];
      pending_q.push_back(r);
    end
  endtask

  function automatic int offset_coord(int p, int d);
    int s;
    s = $urandom_range(0, 1) ? -d : d;
    if (p + s < 0 || p + s > 1023) s = -s;
    return p + s;
  endfunction

  function automatic int pick_coord();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 1023 : 0;
    return $urandom_range(0, 1023);
  endfunction

  task automatic add_random_line();
    int th, span, side, dxm, dym, bx, by, n;
    case ($urandom_range(0, 7))
      0:       th = 0;
      1:       th = $urandom_range(16, 63);
      default: th = $urandom_range(1, 4);
    endcase
    if (th >= 16) span = $urandom_range(0, 2);
    else if ($urandom_range(0, 15) == 0) span = $urandom_range(20, 60);
    else span = $urandom_range(0, 8);
    side = $urandom_range(0, span);
    if ($urandom_range(0, 1)) begin
      dxm = span;
      dym = side;
    end else begin
      dxm = side;
      dym = span;
    end
    bx = pick_coord();
    by = pick_coord();
    add_start(bx, by, offset_coord(bx, dxm), offset_coord(by, dym),
              $urandom_range(0, 255), th);
    // mostly complete lines; some cut short by the next start
    if ($urandom_range(0, 7) == 0) n = $urandom_range(0, span * th);
    else n = span * th + $urandom_range(0, 2);
    add_advances(n);
  endtask

  // sender: bursts and gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        pixel_exp_q.push_back(raster_step(line_req_t'{
          func: in_req.func, x0: in_req.begin_x, y0: in_req.begin_y,
          x1: in_req.finish_x, y1: in_req.finish_y,
          color: in_req.draw_color, thick: in_req.thickness}));
        n_accepted <= n_accepted + 1;
      end
      if (!in_req.valid || in_req.ready) begin
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          in_req.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          next_req = pending_q.pop_front();
          in_req.valid      <= 1'b1;
          in_req.func       <= next_req.func;
          in_req.begin_x    <= next_req.x0;
          in_req.begin_y    <= next_req.y0;
          in_req.finish_x   <= next_req.x1;
          in_req.finish_y   <= next_req.y1;
          in_req.draw_color <= next_req.color;
          in_req.thickness  <= next_req.thick;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once the run is well under way
  int hold_cycles = 0;
  bit hold_done   = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
    end else if (n_accepted >= 400 && !hold_done) begin
      hold_cycles <= 250;
      hold_done   <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // receiver stall pattern
  int         stall_mode  = 0;
  int         mode_cycles = 0;
  logic [7:0] stall_bits  = 8'h01;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
      stall_mode    <= 0;
      mode_cycles   <= 0;
    end else begin
      if (mode_cycles == 0) begin
        stall_mode  <= $urandom_range(0, 3);
        mode_cycles <= $urandom_range(16, 96);
        stall_bits  <= 8'($urandom) | 8'h01;
      end else begin
        mode_cycles <= mode_cycles - 1;
        stall_bits  <= {stall_bits[6:0], stall_bits[7]};
      end
      case (stall_mode)
        0:       out_rsp.ready <= hold_cycles == 0;
        1:       out_rsp.ready <= hold_cycles == 0 && $urandom_range(0, 1) == 1;
        2:       out_rsp.ready <= hold_cycles == 0 && $urandom_range(0, 3) == 0;
        default: out_rsp.ready <= hold_cycles == 0 && stall_bits[7];
      endcase
    end
  end

  // response checker
  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      got_rsp.pvalid = out_rsp.pixel_valid;
      got_rsp.x      = out_rsp.pixel_x;
      got_rsp.y      = out_rsp.pixel_y;
      got_rsp.color  = out_rsp.pixel_color;
      got_rsp.last   = out_rsp.last_pixel;
      if (pixel_exp_q.size() == 0) begin
        report_mismatch("unexpected response", got_rsp, '0);
      end else begin
        want_rsp = pixel_exp_q.pop_front();
        if (got_rsp !== want_rsp) report_mismatch("response mismatch", got_rsp, want_rsp);
        if (want_rsp.pvalid) n_pixels++;
        else n_idle_rsp++;
        if (want_rsp.last) n_completed++;
      end
    end
  end

  initial begin
    in_req.valid      = 1'b0;
    in_req.func       = tlpg_pkg::FUNC_START;
    in_req.begin_x    = '0;
    in_req.begin_y    = '0;
    in_req.finish_x   = '0;
    in_req.finish_y   = '0;
    in_req.draw_color = '0;
    in_req.thickness  = '0;
    out_rsp.ready     = 1'b0;

    add_advances(1);
    add_start(5, 5, 5, 5, 8'h00, 4);
    add_advances(1);
    add_start(0, 0, 1023, 1023, 8'hFF, 0);
    add_advances(1);
    add_start(0, 1023, 2, 1020, 8'hA5, 1);
    add_advances(4);
    add_start(1023, 0, 1021, 1, 8'h5A, 2);
    add_advances(4);
    add_start(100, 200, 101, 205, 8'h3C, 1);
    add_advances(2);
    add_start(40, 40, 43, 38, 8'hC3, 1);
    add_advances(3);

    while (pending_q.size() < 1072) add_random_line();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_req.valid || pixel_exp_q.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);

    $display("%0d requests, %0d line starts: %0d pixels and %0d idle responses checked",
             n_accepted, n_starts, n_pixels, n_idle_rsp);
    $display("%0d lines drawn to their last pixel, %0d mismatches", n_completed, n_errors);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
